@@ src/kmh_pkg.sv @@
// ----------------------------------------------------------------------------
// kmh_pkg
// Types and constants shared by the k-mer MinHash sketch core.
// ----------------------------------------------------------------------------
package kmh_pkg;

  localparam int SKETCH_SIZE = 16;
  localparam int IDX_W       = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
  localparam int KMER_W      = 64;
  localparam int KLEN_W      = 6;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd31;
  localparam logic [KLEN_W-1:0] KLEN_MIN   = 6'd1;
  localparam logic [KLEN_W-1:0] KLEN_MAX   = 6'd32;

  localparam logic [KMER_W-1:0] MIX_MULT = 64'd2685821657736338717;
  localparam int MIX_SH_A = 12;
  localparam int MIX_SH_B = 25;
  localparam int MIX_SH_C = 27;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // One beat moving down the slot chain.
  typedef struct packed {
    logic              vld;    // beat present
    logic              kv;     // carries a complete canonical k-mer
    logic              first;  // first k-mer of the read: fills every slot
    logic              had;    // read has produced at least one k-mer so far
    logic              eor;    // last base of the read
    logic [KMER_W-1:0] kmer;
  } kmh_tok_t;

endpackage

@@ src/kmh_mix.sv @@
// ----------------------------------------------------------------------------
// kmh_mix
// Two-stage xorshift64* hash: shifts and 32-bit partial products, then the sum.
// ----------------------------------------------------------------------------
module kmh_mix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmh_pkg::kmh_tok_t      tok_i,
  input  logic [63:0]            x_i,
  output kmh_pkg::kmh_tok_t      tok_o,
  output logic [63:0]            h_o
);
  import kmh_pkg::*;

  logic [63:0] xa, xb, xc;
  logic [63:0] pll_nxt;
  logic [31:0] phl_nxt, plh_nxt;

  logic [63:0] pll_r;
  logic [31:0] phl_r, plh_r;
  kmh_tok_t    tok1_r;
  kmh_tok_t    tok2_r;
  logic [63:0] h_r;

  always_comb begin
    xa = x_i ^ (x_i >> MIX_SH_A);
    xb = xa ^ (xa << MIX_SH_B);
    xc = xb ^ (xb >> MIX_SH_C);
    // Low 64 bits of the product from three 32x32 partial products.
    pll_nxt = 64'(xc[31:0]) * 64'(MIX_MULT[31:0]);
    phl_nxt = 32'(xc[63:32] * MIX_MULT[31:0]);
    plh_nxt = 32'(xc[31:0] * MIX_MULT[63:32]);
  end

  always_ff @(posedge clk) begin
    pll_r  <= pll_nxt;
    phl_r  <= phl_nxt;
    plh_r  <= plh_nxt;
    h_r    <= pll_r + {phl_r + plh_r, 32'd0};
    if (!rst_n) begin
      tok1_r.vld <= 1'b0;
      tok2_r.vld <= 1'b0;
    end else begin
      tok1_r <= tok_i;
      tok2_r <= tok1_r;
    end
  end

  assign tok_o = tok2_r;
  assign h_o   = h_r;

endmodule

@@ src/kmh_cell.sv @@
// ----------------------------------------------------------------------------
// kmh_cell
// One sketch slot: keeps the least hash seen and its k-mer, and passes the
// rehashed value to the next slot.
// ----------------------------------------------------------------------------
module kmh_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmh_pkg::kmh_tok_t      tok_i,
  input  logic [63:0]            hash_i,
  output kmh_pkg::kmh_tok_t      tok_o,
  output logic [63:0]            hash_o,
  output logic [63:0]            kmer_o
);
  import kmh_pkg::*;

  logic [63:0] hash_r;
  logic [63:0] kmer_r;
  logic        take;

  assign take = tok_i.vld && tok_i.kv && (tok_i.first || (hash_i < hash_r));

  always_ff @(posedge clk) begin
    if (take) begin
      hash_r <= hash_i;
      kmer_r <= tok_i.kmer;
    end
  end

  kmh_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .tok_i (tok_i),
    .x_i   (hash_i),
    .tok_o (tok_o),
    .h_o   (hash_o)
  );

  assign kmer_o = kmer_r;

endmodule

@@ src/kmh_front.sv @@
// ----------------------------------------------------------------------------
// kmh_front
// Rolling forward and reverse-complement k-mers, canonical choice and the
// first hash of each k-mer.
// ----------------------------------------------------------------------------
module kmh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [kmh_pkg::KLEN_W-1:0]    kmer_length,
  input  logic                          accept,
  input  logic [7:0]                    base_char,
  input  logic                          end_of_read,
  output kmh_pkg::kmh_tok_t             tok_o,
  output logic [63:0]                   hash_o
);
  import kmh_pkg::*;

  logic [63:0]       fwd_r, rev_r;
  logic [KLEN_W-1:0] seen_r;
  logic              started_r;
  kmh_tok_t          tok_r;

  logic [KLEN_W-1:0] k;
  logic [6:0]        sh2k;
  logic [63:0]       mask;
  logic [1:0]        v;
  logic [63:0]       fwd_nxt, rev_nxt;
  logic [KLEN_W-1:0] seen_c, seen_nxt;
  logic              kv;

  always_comb begin
    if (kmer_length < KLEN_MIN) k = KLEN_MIN;
    else if (kmer_length > KLEN_MAX) k = KLEN_MAX;
    else k = kmer_length;
    sh2k = {k, 1'b0};
    mask = {64{1'b1}} >> (7'd64 - sh2k);

    unique case (base_char)
      8'h43, 8'h63: v = BASE_C;
      8'h47, 8'h67: v = BASE_G;
      8'h54, 8'h74: v = BASE_T;
      default:      v = BASE_A;
    endcase

    fwd_nxt = {fwd_r[61:0], v} & mask;
    rev_nxt = ((rev_r >> 2) | (64'(BASE_T - v) << (sh2k - 7'd2))) & mask;

    seen_c   = (seen_r > k) ? k : seen_r;
    seen_nxt = (seen_c < k) ? seen_c + 6'd1 : seen_c;
    kv       = (seen_nxt >= k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r     <= '0;
      rev_r     <= '0;
      seen_r    <= '0;
      started_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= accept;
      if (accept) begin
        tok_r.kv    <= kv;
        tok_r.first <= kv && !started_r;
        tok_r.had   <= kv || started_r;
        tok_r.eor   <= end_of_read;
        tok_r.kmer  <= (fwd_nxt < rev_nxt) ? fwd_nxt : rev_nxt;
        if (end_of_read) begin
          fwd_r     <= '0;
          rev_r     <= '0;
          seen_r    <= '0;
          started_r <= 1'b0;
        end else begin
          fwd_r     <= fwd_nxt;
          rev_r     <= rev_nxt;
          seen_r    <= seen_nxt;
          started_r <= started_r || kv;
        end
      end
    end
  end

  kmh_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .tok_i (tok_r),
    .x_i   (tok_r.kmer),
    .tok_o (tok_o),
    .h_o   (hash_o)
  );

endmodule

@@ src/kmer_minhash_sketch_core.sv @@
// ----------------------------------------------------------------------------
// kmer_minhash_sketch_core
// Streaming MinHash sketch over the canonical k-mers of a read.
// ----------------------------------------------------------------------------
// Usage: bases arrive on the in_ channel, one ASCII character per beat, with
// in_end_of_read marking the last base of a read. Within a read the core
// takes one base per cycle. After the last base is accepted, in_stall stays
// high until the whole sketch has been delivered.
// Each k-mer walks down a row of SKETCH_SIZE slot cells; every cell compares
// its hash against its stored minimum and rehashes it for the next cell
// through its registered mixer. After the end-of-read beat leaves the last
// cell, SKETCH_SIZE result beats follow, one per cycle when out_stall is low.
// When out_stall is high the current result beat holds. cfg_wr_en writes k
// (kmer_length); write it only while idle.
// Reset (rst_n low, synchronous) sets k to 31 and clears the rolling k-mers
// and all flow control; the slot contents are rewritten by each read's first
// k-mer.
// ----------------------------------------------------------------------------
module kmer_minhash_sketch_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kmh_pkg::KLEN_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_base_char,
  input  logic                          in_end_of_read,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_slot_index,
  output logic [63:0]                   out_slot_kmer,
  output logic                          out_slot_empty,
  output logic                          out_last_slot
);
  import kmh_pkg::*;

  logic [KLEN_W-1:0] klen_r;
  logic              busy_r;
  logic              emit_r;
  logic              empty_r;
  logic [IDX_W-1:0]  idx_r;

  logic              in_acc;
  logic              out_acc;
  logic              drained;
  logic              at_last;

  kmh_tok_t    chain_tok  [SKETCH_SIZE+1];
  logic [63:0] chain_hash [SKETCH_SIZE+1];
  logic [63:0] slot_kmer  [SKETCH_SIZE];

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_acc  = emit_r && !out_stall;
  assign drained  = chain_tok[SKETCH_SIZE].vld && chain_tok[SKETCH_SIZE].eor;
  assign at_last  = (idx_r == IDX_W'(SKETCH_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_RESET;
    end else if (cfg_wr_en) begin
      klen_r <= cfg_wr_data;
    end
  end

  kmh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .kmer_length (klen_r),
    .accept      (in_acc),
    .base_char   (in_base_char),
    .end_of_read (in_end_of_read),
    .tok_o       (chain_tok[0]),
    .hash_o      (chain_hash[0])
  );

  for (genvar j = 0; j < SKETCH_SIZE; j++) begin : g_cell
    kmh_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (chain_tok[j]),
      .hash_i (chain_hash[j]),
      .tok_o  (chain_tok[j+1]),
      .hash_o (chain_hash[j+1]),
      .kmer_o (slot_kmer[j])
    );
  end

  // The end-of-read beat leaving the last cell means every slot is final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      emit_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (in_acc && in_end_of_read) begin
        busy_r <= 1'b1;
      end
      if (drained) begin
        emit_r  <= 1'b1;
        idx_r   <= '0;
        empty_r <= !chain_tok[SKETCH_SIZE].had;
      end else if (out_acc) begin
        if (at_last) begin
          emit_r <= 1'b0;
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  assign out_valid      = emit_r;
  assign out_slot_index = 4'(idx_r);
  assign out_slot_kmer  = empty_r ? 64'd0 : slot_kmer[idx_r];
  assign out_slot_empty = empty_r;
  assign out_last_slot  = at_last;

  a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> busy_r)
    else $error("result beat offered while input side is open");

  a_eor_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_read) |=> in_stall)
    else $error("input not closed after last base of a read");

  a_drain_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    drained |-> (busy_r && !emit_r))
    else $error("end-of-read beat left the chain outside a pending read");

  a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !at_last) |=> (emit_r && idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("sketch emission stopped before the last slot");

endmodule

@@ verif/kmer_minhash_sketch_core_tb.sv @@
// ----------------------------------------------------------------------------
// kmer_minhash_sketch_core testbench
// Streams reads of ASCII bases into the core under several k settings and
// flow-control patterns. A scoreboard predicts every sketch beat from the
// accepted bases and checks each result beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kmh_pkg::*;

  localparam int DRAIN_CYCLES   = 3 * SKETCH_SIZE + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 45;
  localparam int NUM_PHASES     = 8;

  // Rolling canonical k-mer tracker and per-slot minimum store, with the queue
  // of sketch beats that the core still owes.
  class sketch_checker;
    typedef struct {
      bit [3:0]  idx;
      bit [63:0] kmer;
      bit        empty;
      bit        is_last;
    } slot_rec_t;

    slot_rec_t       expected_slots[$];
    bit [KLEN_W-1:0] klen;
    bit [63:0]       fwd;
    bit [63:0]       rev;
    int unsigned     seen;
    bit              started;
    bit [63:0]       min_hash[SKETCH_SIZE];
    bit [63:0]       min_kmer[SKETCH_SIZE];
    int unsigned     errors;
    int unsigned     slots_checked;

    function new();
      klen = KLEN_RESET;
      clear_read();
    endfunction

    function void clear_read();
      fwd     = '0;
      rev     = '0;
      seen    = 0;
      started = 1'b0;
    endfunction

    function int unsigned eff_klen();
      if (klen < KLEN_MIN) return KLEN_MIN;
      if (klen > KLEN_MAX) return KLEN_MAX;
      return klen;
    endfunction

    function bit [63:0] xorshift_mix(bit [63:0] x);
      x = x ^ (x >> MIX_SH_A);
      x = x ^ (x << MIX_SH_B);
      x = x ^ (x >> MIX_SH_C);
      return x * MIX_MULT;
    endfunction

    function void take_base(bit [7:0] ch, bit eor);
      int unsigned k;
      int          j;
      bit [63:0]   mask;
      bit [63:0]   v;
      bit [63:0]   canon;
      bit [63:0]   h;
      slot_rec_t   rec;
      k    = eff_klen();
      mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      case (ch)
        "C", "c": v = BASE_C;
        "G", "g": v = BASE_G;
        "T", "t": v = BASE_T;
        default:  v = BASE_A;
      endcase
      fwd = ((fwd << 2) | v) & mask;
      rev = ((rev >> 2) | ((64'd3 - v) << (2 * k - 2))) & mask;
      // A smaller k written mid-read clamps the count of bases already held.
      if (seen > k) seen = k;
      if (seen < k) seen++;
      if (seen >= k) begin
        canon = (fwd < rev) ? fwd : rev;
        h = xorshift_mix(canon);
        for (j = 0; j < SKETCH_SIZE; j++) begin
          if (!started || h < min_hash[j]) begin
            min_hash[j] = h;
            min_kmer[j] = canon;
          end
          h = xorshift_mix(h);
        end
        started = 1'b1;
      end
      if (eor) begin
        for (j = 0; j < SKETCH_SIZE; j++) begin
          rec.idx     = j[3:0];
          rec.kmer    = started ? min_kmer[j] : 64'd0;
          rec.empty   = !started;
          rec.is_last = (j == SKETCH_SIZE - 1);
          expected_slots = {expected_slots, rec};
        end
        clear_read();
      end
    endfunction

    function void check_slot(logic [3:0] idx, logic [63:0] kmer, logic empty,
                             logic is_last);
      slot_rec_t want;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected sketch beat: slot %0d kmer %h empty %b last %b",
                 $time, idx, kmer, empty, is_last);
        errors++;
        return;
      end
      want = expected_slots.pop_front();
      slots_checked++;
      if (idx !== want.idx) begin
        $display("%0t: slot_index expected %0d actual %0d", $time, want.idx, idx);
        errors++;
      end
      if (kmer !== want.kmer) begin
        $display("%0t: slot %0d slot_kmer expected %h actual %h",
                 $time, want.idx, want.kmer, kmer);
        errors++;
      end
      if (empty !== want.empty) begin
        $display("%0t: slot %0d slot_empty expected %b actual %b",
                 $time, want.idx, want.empty, empty);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: slot %0d last_slot expected %b actual %b",
                 $time, want.idx, want.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic [KLEN_W-1:0] cfg_wr_data    = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [7:0]        in_base_char   = '0;
  logic              in_end_of_read = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [3:0]        out_slot_index;
  logic [63:0]       out_slot_kmer;
  logic              out_slot_empty;
  logic              out_last_slot;

  sketch_checker sb;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   bases_sent    = 0;
  int unsigned   reads_sent    = 0;
  int unsigned   klen_writes   = 0;

  kmer_minhash_sketch_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_char   (in_base_char),
    .in_end_of_read (in_end_of_read),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_slot_kmer  (out_slot_kmer),
    .out_slot_empty (out_slot_empty),
    .out_last_slot  (out_last_slot)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  // Scoreboard hookup and watchdog: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_slot(out_slot_index, out_slot_kmer, out_slot_empty, out_last_slot);
      if (in_valid && !in_stall)
        sb.take_base(in_base_char, in_end_of_read);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d sketch beats pending",
                   $time, quiet_cycles, sb.expected_slots.size());
          $display("FAIL kmer_minhash_sketch_core");
          $finish;
        end
      end
    end
  end

  // Presents one base and returns at the edge where it is taken.
  task automatic send_base(input bit [7:0] ch, input bit eor);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_base_char   = ch;
    in_end_of_read = eor;
    do @(posedge clk); while (in_stall);
    bases_sent++;
    if (eor) reads_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_klen(input bit [KLEN_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.klen     = value;
    klen_writes++;
  endtask

  function automatic bit [7:0] pick_char();
    bit [7:0] alphabet[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, 7)];
  endfunction

  task automatic send_read(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_base(pick_char(), i == len - 1);
  endtask

  task automatic run_phase(input bit [KLEN_W-1:0] klen, input int unsigned mode);
    int unsigned start;
    int unsigned k;
    int unsigned len;
    wait_idle();
    send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 11 : 0;
    stall_pct     = (mode == 2) ? 57 : (mode == 3) ? 11 : 0;
    write_klen(klen);
    k     = sb.eff_klen();
    start = bases_sent;
    while (bases_sent - start < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = (k > 1) ? $urandom_range(1, k - 1) : 1;
        1:       len = $urandom_range(1, 2 * k + 8);
        default: len = $urandom_range(k, k + 12);
      endcase
      send_read(len);
    end
  endtask

  initial begin
    bit [KLEN_W-1:0] phase_klen[NUM_PHASES] = '{6'd1, 6'd32, 6'd2, 6'd63,
                                                6'd5, 6'd0, 6'd17, 6'd40};
    int unsigned p;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset value of k: a one-base read leaves the whole sketch empty.
    send_base("A", 1'b1);

    // Short k with both cases and unknown characters, several k-mers per read.
    wait_idle();
    write_klen(6'd3);
    send_base("A", 1'b0);
    send_base("c", 1'b0);
    send_base("G", 1'b0);
    send_base("t", 1'b0);
    send_base(8'hFF, 1'b0);
    send_base(8'h00, 1'b1);

    // A zero k behaves as one base per k-mer.
    wait_idle();
    write_klen(6'd0);
    send_base("T", 1'b0);
    send_base("g", 1'b1);

    // Anything above 32 behaves as 32, so one base is a short read.
    wait_idle();
    write_klen(6'd63);
    send_base("G", 1'b1);

    // k drops from 4 to 2 in the middle of a read.
    wait_idle();
    write_klen(6'd4);
    send_base("A", 1'b0);
    send_base("C", 1'b0);
    send_base("G", 1'b0);
    send_base("T", 1'b0);
    send_base("A", 1'b0);
    wait_idle();
    write_klen(6'd2);
    send_base("C", 1'b0);
    send_base("G", 1'b1);

    for (p = 0; p < NUM_PHASES; p++)
      run_phase((p == 6) ? 6'($urandom_range(3, 30)) : phase_klen[p], p % 4);

    wait_idle();
    $display("Covered %0d reads (%0d bases) over %0d k settings; %0d sketch beats checked.",
             reads_sent, bases_sent, klen_writes, sb.slots_checked);
    $display("Flow control ran free, with sender gaps, receiver stalls, and both.");
    if (sb.errors == 0) begin
      $display("PASS kmer_minhash_sketch_core");
    end else begin
      $display("FAIL kmer_minhash_sketch_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/kmh_pkg.sv
src/kmh_mix.sv
src/kmh_cell.sv
src/kmh_front.sv
src/kmer_minhash_sketch_core.sv
verif/kmer_minhash_sketch_core_tb.sv
